// File: rtl/rcpc_pkg.sv
// ----------------------------------------------------------------------------
// rcpc_pkg
// Shared types and constants for the rounded corner pixel crop pipeline.
// ----------------------------------------------------------------------------
package rcpc_pkg;

  // pixel coordinate width on the input channel
  localparam int COORD_BITS = 13;

  // signed width for rectangle and pixel geometry (rect edge + size fits 17)
  localparam int GEO_W = (COORD_BITS + 1 > 17) ? COORD_BITS + 1 : 17;

  localparam int RAD_W   = 12;              // clamped radius
  localparam int MAG_W   = RAD_W + 1;       // |2*offset+1| in half-pixel units
  localparam int SQ_W    = 2 * MAG_W + 1;   // dx^2 + dy^2
  localparam int SQ_SHL  = 14;              // Q.8 result needs radicand << 14
  localparam int RDC_W   = 42;              // radicand, even width >= SQ_W + SQ_SHL
  localparam int ROOT_W  = RDC_W / 2;
  localparam int REM_W   = ROOT_W + 1;
  localparam int SQRT_SPS = 2;              // root bits resolved per stage
  localparam int SQRT_NS  = (ROOT_W + SQRT_SPS - 1) / SQRT_SPS;

  localparam int PADDR_W = 5;

  typedef struct packed {
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic [31:0]           pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        in_corner;
  } out_item_t;

  typedef struct packed {
    logic signed [13:0]    rect_x;
    logic signed [13:0]    rect_y;
    logic [12:0]           rect_width;
    logic [12:0]           rect_height;
    logic [3:0][RAD_W-1:0] radius;   // top-left, top-right, bottom-left, bottom-right
  } cfg_t;

  // corner geometry result, squared distance still to be rooted
  typedef struct packed {
    logic              flag;
    logic [RAD_W-1:0]  r;
    logic [31:0]       pixel;
    logic [SQ_W-1:0]   sq;
  } geo_t;

  // distance in Q.8 pixels
  typedef struct packed {
    logic              flag;
    logic [RAD_W-1:0]  r;
    logic [31:0]       pixel;
    logic [ROOT_W-1:0] d;
  } dist_t;

endpackage

// File: rtl/rcpc_geom.sv
// ----------------------------------------------------------------------------
// rcpc_geom
// Corner selection, arc-center offsets and squared distance, three stages.
// ----------------------------------------------------------------------------
module rcpc_geom (
  input  logic               clk,
  input  logic               rst_n,
  input  rcpc_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  rcpc_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rcpc_pkg::geo_t     out_data
);

  localparam int GW = rcpc_pkg::GEO_W;
  localparam int RW = rcpc_pkg::RAD_W;
  localparam int MW = rcpc_pkg::MAG_W;

  // corner squares; static while items are in flight only if the user does not write cfg
  logic [RW-1:0]        half;
  logic [RW-1:0]        rc [4];
  logic signed [GW-1:0] sx [4];
  logic signed [GW-1:0] ex [4];
  logic signed [GW-1:0] cx [4];
  logic signed [GW-1:0] sy [4];
  logic signed [GW-1:0] ey [4];
  logic signed [GW-1:0] cy [4];

  always_comb begin
    logic signed [GW-1:0] xs, ys, ws, hs, rs;
    xs = GW'(cfg.rect_x);
    ys = GW'(cfg.rect_y);
    ws = GW'(cfg.rect_width);
    hs = GW'(cfg.rect_height);
    half = (cfg.rect_width[12:1] < cfg.rect_height[12:1]) ?
           cfg.rect_width[12:1] : cfg.rect_height[12:1];
    for (int i = 0; i < 4; i++) begin
      rc[i] = (cfg.radius[i] < half) ? cfg.radius[i] : half;
      rs    = GW'(rc[i]);
      // bit 0 of the corner index: right side, bit 1: bottom side
      if (i[0] == 1'b0) begin
        sx[i] = xs;
        cx[i] = xs + rs;
      end else begin
        sx[i] = xs + ws - rs;
        cx[i] = sx[i];
      end
      if (i[1] == 1'b0) begin
        sy[i] = ys;
        cy[i] = ys + rs;
      end else begin
        sy[i] = ys + hs - rs;
        cy[i] = sy[i];
      end
      ex[i] = sx[i] + rs;
      ey[i] = sy[i] + rs;
    end
  end

  // stage 1: corner hit and offsets
  logic          v1_r, flag1_r;
  logic [RW-1:0] r1_r;
  logic [MW-1:0] mx1_r, my1_r;
  logic [31:0]   pix1_r;
  logic          flag1_nxt;
  logic [RW-1:0] r1_nxt;
  logic [MW-1:0] mx1_nxt, my1_nxt;

  always_comb begin
    logic signed [GW-1:0] pxs, pys, dx, dy, ax, ay;
    logic [1:0]           sel;
    pxs = GW'(in_data.pix_x);
    pys = GW'(in_data.pix_y);
    flag1_nxt = 1'b0;
    sel = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (rc[i] != '0 && pxs >= sx[i] && pxs < ex[i] && pys >= sy[i] && pys < ey[i]) begin
        flag1_nxt = 1'b1;
        sel = 2'(i);
      end
    end
    dx = pxs - cx[sel];
    dy = pys - cy[sel];
    // 2*off+1 is odd; for negative off its magnitude is 2*~off+1
    ax = dx[GW-1] ? ~dx : dx;
    ay = dy[GW-1] ? ~dy : dy;
    mx1_nxt = {ax[RW-1:0], 1'b1};
    my1_nxt = {ay[RW-1:0], 1'b1};
    r1_nxt  = rc[sel];
  end

  // stage 2: squares
  logic            v2_r, flag2_r;
  logic [RW-1:0]   r2_r;
  logic [2*MW-1:0] sqx2_r, sqy2_r;
  logic [31:0]     pix2_r;

  // stage 3: sum
  logic           v3_r;
  rcpc_pkg::geo_t geo3_r;

  logic [2:0] hold;
  assign hold[2]  = v3_r & out_stall;
  assign hold[1]  = v2_r & hold[2];
  assign hold[0]  = v1_r & hold[1];
  assign in_stall = hold[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (!hold[0]) v1_r <= in_valid;
      if (!hold[1]) v2_r <= v1_r;
      if (!hold[2]) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      flag1_r <= flag1_nxt;
      r1_r    <= r1_nxt;
      mx1_r   <= mx1_nxt;
      my1_r   <= my1_nxt;
      pix1_r  <= in_data.pixel_in;
    end
    if (!hold[1]) begin
      flag2_r <= flag1_r;
      r2_r    <= r1_r;
      sqx2_r  <= mx1_r * mx1_r;
      sqy2_r  <= my1_r * my1_r;
      pix2_r  <= pix1_r;
    end
    if (!hold[2]) begin
      geo3_r.flag  <= flag2_r;
      geo3_r.r     <= r2_r;
      geo3_r.pixel <= pix2_r;
      geo3_r.sq    <= rcpc_pkg::SQ_W'(sqx2_r) + rcpc_pkg::SQ_W'(sqy2_r);
    end
  end

  assign out_valid = v3_r;
  assign out_data  = geo3_r;

endmodule

// File: rtl/rcpc_sqrt.sv
// ----------------------------------------------------------------------------
// rcpc_sqrt
// Pipelined digit-by-digit integer square root, a fixed number of root bits
// resolved per stage.
// ----------------------------------------------------------------------------
module rcpc_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  rcpc_pkg::geo_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rcpc_pkg::dist_t out_data
);

  localparam int NS  = rcpc_pkg::SQRT_NS;
  localparam int SPS = rcpc_pkg::SQRT_SPS;
  localparam int QW  = rcpc_pkg::ROOT_W;
  localparam int MW  = rcpc_pkg::REM_W;
  localparam int DW  = rcpc_pkg::RDC_W;

  typedef struct packed {
    logic                       flag;
    logic [rcpc_pkg::RAD_W-1:0] r;
    logic [31:0]                pixel;
  } side_t;

  logic          v_r    [NS];
  logic [MW-1:0] rem_r  [NS];
  logic [QW-1:0] root_r [NS];
  logic [DW-1:0] rad_r  [NS];
  side_t         side_r [NS];
  logic [NS-1:0] hold;

  always_comb begin
    hold[NS-1] = v_r[NS-1] & out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      hold[k] = v_r[k] & hold[k+1];
    end
  end
  assign in_stall = hold[0];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          v_i;
    logic [MW-1:0] rem_i, rem_nxt;
    logic [QW-1:0] root_i, root_nxt;
    logic [DW-1:0] rad_i, rad_nxt;
    side_t         side_i;

    if (s == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = DW'({in_data.sq, {rcpc_pkg::SQ_SHL{1'b0}}});
      assign side_i = '{flag: in_data.flag, r: in_data.r, pixel: in_data.pixel};
    end else begin : g_next
      assign v_i    = v_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign root_i = root_r[s-1];
      assign rad_i  = rad_r[s-1];
      assign side_i = side_r[s-1];
    end

    always_comb begin
      logic [MW+1:0] cur, trial;
      rem_nxt  = rem_i;
      root_nxt = root_i;
      rad_nxt  = rad_i;
      for (int j = 0; j < SPS; j++) begin
        if (s * SPS + j < QW) begin
          cur   = {rem_nxt, rad_nxt[DW-1 -: 2]};
          trial = {1'b0, root_nxt, 2'b01};
          if (cur >= trial) begin
            rem_nxt  = MW'(cur - trial);
            root_nxt = {root_nxt[QW-2:0], 1'b1};
          end else begin
            rem_nxt  = cur[MW-1:0];
            root_nxt = {root_nxt[QW-2:0], 1'b0};
          end
          rad_nxt = {rad_nxt[DW-3:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (!hold[s]) begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (!hold[s]) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        rad_r[s]  <= rad_nxt;
        side_r[s] <= side_i;
      end
    end
  end

  assign out_valid      = v_r[NS-1];
  assign out_data.flag  = side_r[NS-1].flag;
  assign out_data.r     = side_r[NS-1].r;
  assign out_data.pixel = side_r[NS-1].pixel;
  assign out_data.d     = root_r[NS-1];

  // partial remainder never exceeds twice the partial root
  for (genvar s = 0; s < NS; s++) begin : g_chk
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
      v_r[s] |-> ({1'b0, rem_r[s]} <= {1'b0, root_r[s], 1'b0}))
      else $error("sqrt remainder out of bound");
  end

endmodule

// File: rtl/rcpc_cover.sv
// ----------------------------------------------------------------------------
// rcpc_cover
// Smoothstep coverage over the one-pixel band and channel scaling.
// ----------------------------------------------------------------------------
module rcpc_cover (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rcpc_pkg::dist_t     in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rcpc_pkg::out_item_t out_data
);

  localparam int QW = rcpc_pkg::ROOT_W;
  localparam int PW = 26;   // t^2 * (768 - 2t)

  typedef enum logic [1:0] {
    KEEP_FULL,
    KEEP_ZERO,
    KEEP_BAND
  } keep_mode_t;

  // stage 1: band compare
  logic       v1_r, flag1_r;
  keep_mode_t mode1_r, mode1_nxt;
  logic [7:0] t1_r, t1_nxt;
  logic [31:0] pix1_r;

  always_comb begin
    logic [QW-1:0] lo, hi, diff;
    lo   = {1'b0, in_data.r, 8'd0} - QW'(128);
    hi   = {1'b0, in_data.r, 8'd0} + QW'(128);
    diff = in_data.d - lo;
    t1_nxt = diff[7:0];
    if (!in_data.flag || in_data.d <= lo) begin
      mode1_nxt = KEEP_FULL;
    end else if (in_data.d >= hi) begin
      mode1_nxt = KEEP_ZERO;
    end else begin
      mode1_nxt = KEEP_BAND;
    end
  end

  // stage 2: t^2 and 3 - 2t term
  logic        v2_r, flag2_r;
  keep_mode_t  mode2_r;
  logic [15:0] tt2_r;
  logic [9:0]  w2_r;
  logic [31:0] pix2_r;

  // stage 3: cubic product
  logic          v3_r, flag3_r;
  keep_mode_t    mode3_r;
  logic [PW-1:0] p3_r;
  logic [31:0]   pix3_r;

  // stage 4: keep fraction, Q1.8
  logic        v4_r, flag4_r;
  logic [8:0]  keep4_r, keep4_nxt;
  logic [31:0] pix4_r;

  always_comb begin
    logic [PW:0]   cs;
    logic [PW-16:0] cut;
    cs  = {1'b0, p3_r} + (PW+1)'(32768);
    cut = cs[PW:16];
    case (mode3_r)
      KEEP_FULL: keep4_nxt = 9'd256;
      KEEP_ZERO: keep4_nxt = 9'd0;
      KEEP_BAND: keep4_nxt = (cut > (PW-15)'(256)) ? 9'd0 : 9'd256 - cut[8:0];
      default:   keep4_nxt = 9'd256;
    endcase
  end

  // stage 5: output register
  logic                v5_r;
  rcpc_pkg::out_item_t out5_r, out5_nxt;

  always_comb begin
    logic [15:0] prod;
    out5_nxt.in_corner = flag4_r;
    for (int c = 0; c < 4; c++) begin
      prod = 16'(pix4_r[8*c +: 8]) * 16'(keep4_r) + 16'd128;
      out5_nxt.pixel_out[8*c +: 8] = prod[15:8];
    end
  end

  logic [4:0] hold;
  assign hold[4]  = v5_r & out_stall;
  assign hold[3]  = v4_r & hold[4];
  assign hold[2]  = v3_r & hold[3];
  assign hold[1]  = v2_r & hold[2];
  assign hold[0]  = v1_r & hold[1];
  assign in_stall = hold[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (!hold[0]) v1_r <= in_valid;
      if (!hold[1]) v2_r <= v1_r;
      if (!hold[2]) v3_r <= v2_r;
      if (!hold[3]) v4_r <= v3_r;
      if (!hold[4]) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      flag1_r <= in_data.flag;
      mode1_r <= mode1_nxt;
      t1_r    <= t1_nxt;
      pix1_r  <= in_data.pixel;
    end
    if (!hold[1]) begin
      flag2_r <= flag1_r;
      mode2_r <= mode1_r;
      tt2_r   <= t1_r * t1_r;
      w2_r    <= 10'd768 - {1'b0, t1_r, 1'b0};
      pix2_r  <= pix1_r;
    end
    if (!hold[2]) begin
      flag3_r <= flag2_r;
      mode3_r <= mode2_r;
      p3_r    <= tt2_r * w2_r;
      pix3_r  <= pix2_r;
    end
    if (!hold[3]) begin
      flag4_r <= flag3_r;
      keep4_r <= keep4_nxt;
      pix4_r  <= pix3_r;
    end
    if (!hold[4]) begin
      out5_r <= out5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = out5_r;

  // inside the band t is never zero
  a_band_t: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && mode1_r == KEEP_BAND |-> t1_r != 8'd0)
    else $error("band offset is zero");

endmodule

// File: rtl/rounded_corner_pixel_crop.sv
// ----------------------------------------------------------------------------
// rounded_corner_pixel_crop
// Antialiased rounded-rectangle corner mask for premultiplied ARGB8888 pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one item: pixel column, row and pixel.
//   out_valid/out_stall/out_data return the scaled pixel and a flag set when
//   the pixel lay inside a curved corner square. One result per item, in order.
//   The cfg_ port is an APB-style slave, registers at byte address 4*index:
//   rect_x, rect_y, rect_width, rect_height, then the four radii (top-left,
//   top-right, bottom-left, bottom-right). pready is tied high; write the
//   registers only while no item is in flight.
// Timing:
//   The pipeline has 3 geometry stages, 11 square-root stages (two root
//   bits per stage over a 21-bit root) and 5 coverage/scaling stages.
//   Throughput is one item per cycle while out_stall is low.
// Reset:
//   All registers read 0 and the pipeline is empty; every pixel then passes
//   through with the corner flag low.
// Stall:
//   Each stage holds only when it is full and the stage after it holds, so
//   empty stages keep filling while out_stall is high; in_stall rises once
//   every stage is full.
// ----------------------------------------------------------------------------
module rounded_corner_pixel_crop (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rcpc_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rcpc_pkg::out_item_t              out_data,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [rcpc_pkg::PADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  localparam logic [2:0] REG_RECT_X      = 3'd0;
  localparam logic [2:0] REG_RECT_Y      = 3'd1;
  localparam logic [2:0] REG_RECT_WIDTH  = 3'd2;
  localparam logic [2:0] REG_RECT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_RADIUS_TL   = 3'd4;
  localparam logic [2:0] REG_RADIUS_TR   = 3'd5;
  localparam logic [2:0] REG_RADIUS_BL   = 3'd6;
  localparam logic [2:0] REG_RADIUS_BR   = 3'd7;

  rcpc_pkg::cfg_t cfg_r;
  logic [2:0]     reg_idx;
  logic           cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RECT_X:      cfg_r.rect_x      <= cfg_pwdata[13:0];
        REG_RECT_Y:      cfg_r.rect_y      <= cfg_pwdata[13:0];
        REG_RECT_WIDTH:  cfg_r.rect_width  <= cfg_pwdata[12:0];
        REG_RECT_HEIGHT: cfg_r.rect_height <= cfg_pwdata[12:0];
        REG_RADIUS_TL:   cfg_r.radius[0]   <= cfg_pwdata[11:0];
        REG_RADIUS_TR:   cfg_r.radius[1]   <= cfg_pwdata[11:0];
        REG_RADIUS_BL:   cfg_r.radius[2]   <= cfg_pwdata[11:0];
        REG_RADIUS_BR:   cfg_r.radius[3]   <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RECT_X:      cfg_prdata = 32'(cfg_r.rect_x);
      REG_RECT_Y:      cfg_prdata = 32'(cfg_r.rect_y);
      REG_RECT_WIDTH:  cfg_prdata = 32'(cfg_r.rect_width);
      REG_RECT_HEIGHT: cfg_prdata = 32'(cfg_r.rect_height);
      REG_RADIUS_TL:   cfg_prdata = 32'(cfg_r.radius[0]);
      REG_RADIUS_TR:   cfg_prdata = 32'(cfg_r.radius[1]);
      REG_RADIUS_BL:   cfg_prdata = 32'(cfg_r.radius[2]);
      REG_RADIUS_BR:   cfg_prdata = 32'(cfg_r.radius[3]);
      default:         cfg_prdata = '0;
    endcase
  end

  logic            geo_valid, geo_stall;
  rcpc_pkg::geo_t  geo_data;
  logic            dist_valid, dist_stall;
  rcpc_pkg::dist_t dist_data;

  rcpc_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (geo_valid),
    .out_stall (geo_stall),
    .out_data  (geo_data)
  );

  rcpc_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (geo_valid),
    .in_stall  (geo_stall),
    .in_data   (geo_data),
    .out_valid (dist_valid),
    .out_stall (dist_stall),
    .out_data  (dist_data)
  );

  rcpc_cover u_cover (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dist_valid),
    .in_stall  (dist_stall),
    .in_data   (dist_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // the pipeline only pushes back when the output is full and held
  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && geo_valid && dist_valid)
    else $error("input stalled with empty stages");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams directed and random pixels past a series of programmed rounded
// rectangles. Each accepted item is predicted with a fixed-point model of the
// corner coverage, and every result is checked in order. Both channels idle
// at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int REG_RECT_X      = 0;
  localparam int REG_RECT_Y      = 1;
  localparam int REG_RECT_WIDTH  = 2;
  localparam int REG_RECT_HEIGHT = 3;
  localparam int REG_RADIUS_TL   = 4;
  localparam int REG_RADIUS_TR   = 5;
  localparam int REG_RADIUS_BL   = 6;
  localparam int REG_RADIUS_BR   = 7;

  localparam int CORNER_TL = 0;
  localparam int CORNER_TR = 1;
  localparam int CORNER_BL = 2;
  localparam int CORNER_BR = 3;

  localparam int          CW            = rcpc_pkg::COORD_BITS;
  localparam int          AW            = rcpc_pkg::PADDR_W;
  localparam int          COORD_MAX     = (1 << CW) - 1;
  localparam int          KEEP_ONE      = 256;   // Q1.8 unity
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 40;    // pipeline is 19 deep
  localparam int unsigned CYCLE_LIMIT   = 200000;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  rcpc_pkg::in_item_t  in_data     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b1;
  rcpc_pkg::out_item_t out_data;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [AW-1:0]       cfg_paddr   = '0;
  logic [31:0]         cfg_pwdata  = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  // register shadow
  logic signed [13:0] cfg_rect_x      = '0;
  logic signed [13:0] cfg_rect_y      = '0;
  logic [12:0]        cfg_rect_width  = '0;
  logic [12:0]        cfg_rect_height = '0;
  logic [11:0]        cfg_radius [4]  = '{default: '0};

  rcpc_pkg::in_item_t  pixel_q [$];
  rcpc_pkg::out_item_t expected_q [$];
  logic        in_taken       = 1'b0;
  int          send_idle_pct  = 35;
  int          recv_idle_pct  = 35;
  int          hold_requests  = 0;
  int          hold_served    = 0;
  int          hold_left      = 0;
  bit          junk_bits      = 1'b0;
  int          error_count    = 0;
  int unsigned cycle_count    = 0;

  rounded_corner_pixel_crop dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // coverage prediction
  // --------------------------------------------------------------------------
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // dx2/dy2 in half-pixel units from the arc center, result in Q1.8
  function automatic int corner_keep(longint dx2, longint dy2, longint r);
    longint unsigned sq;
    longint          d, lo, hi, t, cut;
    sq = longint'(dx2 * dx2 + dy2 * dy2);
    d  = longint'(root_floor(sq << 14));
    lo = r * 256 - 128;
    hi = r * 256 + 128;
    if (d <= lo) return KEEP_ONE;
    if (d >= hi) return 0;
    t   = d - lo;
    cut = (t * t * (768 - 2 * t) + 32768) >> 16;
    if (cut > KEEP_ONE) cut = KEEP_ONE;
    return KEEP_ONE - int'(cut);
  endfunction

  function automatic logic [31:0] scale_argb(logic [31:0] px, int keep);
    logic [31:0] res;
    int          c;
    if (keep >= KEEP_ONE) return px;
    if (keep == 0) return '0;
    res = '0;
    for (int s = 0; s < 32; s += 8) begin
      c = px[s +: 8];
      c = (c * keep + 128) >> 8;
      res[s +: 8] = c[7:0];
    end
    return res;
  endfunction

  function automatic rcpc_pkg::out_item_t crop_predict(rcpc_pkg::in_item_t it);
    rcpc_pkg::out_item_t res;
    longint    px, py, x, y, w, h, half, r, sx, sy, cx, cy;
    px = it.pix_x;
    py = it.pix_y;
    x  = cfg_rect_x;
    y  = cfg_rect_y;
    w  = cfg_rect_width;
    h  = cfg_rect_height;
    half = (w / 2 < h / 2) ? w / 2 : h / 2;
    res.pixel_out = it.pixel_in;
    res.in_corner = 1'b0;
    for (int i = 0; i < 4; i++) begin
      r = cfg_radius[i];
      if (r > half) r = half;
      if (!res.in_corner && r > 0) begin
        if (i == CORNER_TL || i == CORNER_BL) begin
          sx = x;
          cx = x + r;
        end else begin
          sx = x + w - r;
          cx = sx;
        end
        if (i == CORNER_TL || i == CORNER_TR) begin
          sy = y;
          cy = y + r;
        end else begin
          sy = y + h - r;
          cy = sy;
        end
        if (px >= sx && px < sx + r && py >= sy && py < sy + r) begin
          res.in_corner = 1'b1;
          res.pixel_out = scale_argb(it.pixel_in,
                                     corner_keep(2 * px + 1 - 2 * cx,
                                                 2 * py + 1 - 2 * cy, r));
        end
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // driver, receiver and monitor
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pixel_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    rcpc_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item %h", out_data));
        end else begin
          want = expected_q.pop_front();
          if (out_data.pixel_out !== want.pixel_out)
            report_mismatch($sformatf("pixel_out %h, expected %h",
                                      out_data.pixel_out, want.pixel_out));
          if (out_data.in_corner !== want.in_corner)
            report_mismatch($sformatf("in_corner %b, expected %b",
                                      out_data.in_corner, want.in_corner));
        end
      end
      in_taken = in_valid && !in_stall;
      if (in_taken) expected_q.push_back(crop_predict(in_data));
    end else begin
      in_taken = 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d items pending", cycle_count,
               expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic write_reg(int idx, int value);
    logic [31:0] mask;
    logic [31:0] data;
    case (idx)
      REG_RECT_X, REG_RECT_Y:           mask = 32'h3fff;
      REG_RECT_WIDTH, REG_RECT_HEIGHT:  mask = 32'h1fff;
      default:                          mask = 32'h0fff;
    endcase
    data = value;
    if (junk_bits) data = (data & mask) | ($urandom & ~mask);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = AW'(idx * 4);
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_RECT_X:      cfg_rect_x      = data[13:0];
      REG_RECT_Y:      cfg_rect_y      = data[13:0];
      REG_RECT_WIDTH:  cfg_rect_width  = data[12:0];
      REG_RECT_HEIGHT: cfg_rect_height = data[12:0];
      default:         cfg_radius[idx - REG_RADIUS_TL] = data[11:0];
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic program_rect(int x, int y, int w, int h, int tl, int tr, int bl,
                              int br);
    write_reg(REG_RECT_X, x);
    write_reg(REG_RECT_Y, y);
    write_reg(REG_RECT_WIDTH, w);
    write_reg(REG_RECT_HEIGHT, h);
    write_reg(REG_RADIUS_TL, tl);
    write_reg(REG_RADIUS_TR, tr);
    write_reg(REG_RADIUS_BL, bl);
    write_reg(REG_RADIUS_BR, br);
  endtask

  task automatic random_geometry(bit wide);
    if (wide)
      program_rect(int'($urandom_range(16383)) - 8192, int'($urandom_range(16383)) - 8192,
                   $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                   $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(4095), $urandom_range(4095));
    else
      program_rect(int'($urandom_range(700)) - 100, int'($urandom_range(700)) - 100,
                   $urandom_range(1, 90), $urandom_range(1, 90),
                   ($urandom_range(3) == 0) ? 0 : $urandom_range(40),
                   ($urandom_range(3) == 0) ? 0 : $urandom_range(40),
                   ($urandom_range(3) == 0) ? 0 : $urandom_range(40),
                   ($urandom_range(3) == 0) ? 0 : $urandom_range(40));
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  // offset from the rectangle start, biased toward both corner bands
  function automatic int edge_offset(int len, int reach);
    case ($urandom_range(2))
      0:       return int'($urandom_range(reach + 5)) - 3;
      1:       return len + 2 - int'($urandom_range(reach + 5));
      default: return int'($urandom_range(len + 5)) - 3;
    endcase
  endfunction

  function automatic logic [31:0] random_argb();
    case ($urandom_range(7))
      0:       return 32'hffff_ffff;
      1:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_item(int x, int y, logic [31:0] p);
    rcpc_pkg::in_item_t it;
    it.pix_x    = CW'(x);
    it.pix_y    = CW'(y);
    it.pixel_in = p;
    pixel_q.push_back(it);
  endtask

  task automatic queue_random(int n);
    int half, reach;
    half  = (cfg_rect_width / 2 < cfg_rect_height / 2) ? cfg_rect_width / 2
                                                       : cfg_rect_height / 2;
    reach = 0;
    for (int i = 0; i < 4; i++)
      if (cfg_radius[i] > reach) reach = cfg_radius[i];
    if (reach > half) reach = half;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0)
        queue_item($urandom_range(COORD_MAX), $urandom_range(COORD_MAX), random_argb());
      else
        queue_item(clamp_coord(int'(cfg_rect_x) + edge_offset(cfg_rect_width, reach)),
                   clamp_coord(int'(cfg_rect_y) + edge_offset(cfg_rect_height, reach)),
                   random_argb());
    end
  endtask

  // every accepted item yields a result, so an empty store means idle
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // registers at reset: zero-size rectangle, everything passes through
    queue_item(0, 0, 32'h0000_0000);
    queue_item(COORD_MAX, COORD_MAX, 32'hffff_ffff);
    queue_item(100, 3, 32'h8040_2010);
    wait_idle();

    // top-right radius clamps to 15, bottom-left radius differs from top-left,
    // bottom-right corner is square
    junk_bits = 1'b1;
    program_rect(10, 20, 40, 30, 8, 20, 5, 0);
    junk_bits = 1'b0;
    queue_item(10, 20, 32'hffff_ffff);
    queue_item(11, 21, 32'hffff_ffff);
    queue_item(12, 22, 32'hff80_40c0);
    queue_item(13, 21, 32'h8040_2010);
    queue_item(14, 20, 32'hffff_ffff);
    queue_item(17, 27, 32'hffff_ffff);
    queue_item(49, 20, 32'hffff_ffff);
    queue_item(46, 21, 32'hc0c0_c0c0);
    queue_item(44, 22, 32'hffff_ffff);
    queue_item(35, 20, 32'h7f7f_7f7f);
    queue_item(10, 49, 32'hffff_ffff);
    queue_item(11, 48, 32'hff00_ff00);
    queue_item(14, 45, 32'hffff_ffff);
    queue_item(49, 49, 32'hffff_ffff);
    queue_item(30, 35, 32'hffff_ffff);
    queue_item(5, 5, 32'h1234_5678);
    queue_item(9, 20, 32'hffff_ffff);
    queue_random(150);
    wait_idle();

    // odd sizes, radii clamp to 8
    program_rect(-3, 7, 31, 17, 20, 8, 3, 12);
    queue_random(150);
    wait_idle();

    // largest rectangle and radii, pixels on the arcs
    program_rect(0, 0, COORD_MAX, COORD_MAX, 4095, 4095, 4095, 4095);
    queue_item(0, 0, 32'hffff_ffff);
    queue_item(0, 4094, 32'hffff_ffff);
    queue_item(8190, 4094, 32'hffff_ffff);
    queue_item(4094, 8190, 32'hffff_ffff);
    queue_item(8190, 8190, 32'hffff_ffff);
    queue_item(1200, 1200, $urandom);
    queue_random(120);
    wait_idle();

    // rectangles at the extremes of the origin range
    program_rect(-8192, -8192, COORD_MAX, COORD_MAX, 4095, 4095, 4095, 4095);
    queue_item(0, 0, 32'hffff_ffff);
    queue_random(40);
    wait_idle();
    program_rect(8191, 8191, COORD_MAX, COORD_MAX, 4095, 4095, 4095, 4095);
    queue_item(COORD_MAX, COORD_MAX, 32'hffff_ffff);
    queue_random(40);
    wait_idle();

    // degenerate sizes: clamped radii are zero
    program_rect(50, 60, 0, 40, 10, 10, 10, 10);
    queue_random(60);
    wait_idle();
    program_rect(50, 60, 40, 1, 10, 10, 10, 10);
    queue_random(30);
    wait_idle();

    // receiver holds off while the sender keeps offering
    random_geometry(1'b0);
    send_idle_pct = 10;
    hold_requests++;
    queue_random(200);
    wait_idle();

    // no idling on either side
    random_geometry(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(200);
    wait_idle();
    send_idle_pct = 35;
    recv_idle_pct = 35;

    for (int j = 0; j < 6; j++) begin
      junk_bits = $urandom_range(1);
      random_geometry(j % 3 == 2);
      queue_random(80);
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/rcpc_pkg.sv
rtl/rcpc_geom.sv
rtl/rcpc_sqrt.sv
rtl/rcpc_cover.sv
rtl/rounded_corner_pixel_crop.sv
dv/testbench.sv
